/* src/hsic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hsic_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_CLEAR      = 2'd0,
    KIND_INSERT     = 2'd1,
    KIND_PROBE_NEW  = 2'd2,
    KIND_PROBE_CONT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result tdata: hit, match_count, best_count, bucket_full, zero fill to 40 bits
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - (2 + 2 * COUNT_W);

endpackage

`default_nettype wire

/* src/hash_set_intersection_counter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Hash-set intersection counter.
// Input stream: tuser carries the item kind (clear, insert, probe new set,
// probe continuing set), tdata the signed 32-bit value. Every accepted item
// yields exactly one result transfer on the output stream.
// The reference set lives in one row-wide RAM: a row per bucket holds WAYS
// values plus the bucket's fill count. The bucket is the value's low bits,
// so BUCKETS must be a power of two.
// Insert and probe: the row read is launched on the input transfer; in the
// evaluation state, once the output register is free, all ways are compared
// at once, the row is written back and the result loaded. No new item is
// taken until that evaluation is done and the block is idle again.
// A clear sweeps the fill counts one bucket per cycle over all BUCKETS rows,
// then loads its result once the output register is free.
// After reset the same sweep runs over all buckets with tready low.
// Results sit in an output register; a new item is accepted while a result
// waits, but the block holds its evaluation while the receiver stalls with
// the output register still full. Counts are kept across clears.
module hash_set_intersection_counter #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] hit, [16:1] match_count, [32:17] best_count, [33] bucket_full, [39:34] zero
  output logic [hsic_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IDX_W  = $clog2(BUCKETS);
  localparam int unsigned FILL_W = $clog2(WAYS + 1);
  localparam int unsigned VW     = hsic_pkg::VALUE_W;
  localparam int unsigned ROW_W  = WAYS * VW + FILL_W;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BUCKETS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WAYS);

  hsic_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic             pend_q, pend_d;

  hsic_pkg::kind_e  kind_q;
  logic [VW-1:0]    value_q;

  logic [hsic_pkg::COUNT_W-1:0] cur_q, best_q;
  logic                         m_valid_q;
  logic [hsic_pkg::OUT_DATA_W-1:0] m_data_q;

  logic [ROW_W-1:0] mem_q [BUCKETS];
  logic [ROW_W-1:0] rd_row_q;

  logic             in_xfer;
  logic             out_free;
  logic             advance;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  // evaluation of the fetched row
  logic [FILL_W-1:0] fill;
  logic              hit;
  logic              full;
  logic              ins_we;
  logic [ROW_W-1:0]  ins_row;
  logic [hsic_pkg::COUNT_W-1:0] cur_nx, best_nx;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign advance  = (state_q == hsic_pkg::ST_EVAL) && out_free;

  // next state
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    pend_d    = pend_q;
    unique case (state_q)
      hsic_pkg::ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_IDX) begin
          clr_idx_d = '0;
          pend_d    = 1'b0;
          state_d   = pend_q ? hsic_pkg::ST_EVAL : hsic_pkg::ST_IDLE;
        end
      end
      hsic_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (hsic_pkg::kind_e'(s_axis_tuser_i) == hsic_pkg::KIND_CLEAR) begin
            pend_d  = 1'b1;
            state_d = hsic_pkg::ST_CLEAR;
          end else begin
            state_d = hsic_pkg::ST_EVAL;
          end
        end
      end
      hsic_pkg::ST_EVAL: begin
        if (out_free) begin
          state_d = hsic_pkg::ST_IDLE;
        end
      end
      default: state_d = hsic_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = value_q[IDX_W-1:0];
    mem_wdata       = ins_row;
    unique case (state_q)
      hsic_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
      end
      hsic_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      hsic_pkg::ST_EVAL: begin
        mem_we = out_free && ins_we;
      end
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  // compare all ways, build the write-back row and the new counts
  always_comb begin
    logic                         match;
    logic [hsic_pkg::COUNT_W-1:0] cnt;
    fill    = rd_row_q[ROW_W-1 -: FILL_W];
    match   = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if ((FILL_W'(w) < fill) && (rd_row_q[w*VW +: VW] == value_q)) begin
        match = 1'b1;
      end
    end
    ins_row = rd_row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) == fill) begin
        ins_row[w*VW +: VW] = value_q;
      end
    end
    ins_row[ROW_W-1 -: FILL_W] = fill + 1'b1;

    hit     = 1'b0;
    full    = 1'b0;
    ins_we  = 1'b0;
    cur_nx  = cur_q;
    best_nx = best_q;
    cnt     = cur_q;
    case (kind_q) inside
      hsic_pkg::KIND_INSERT: begin
        hit = match;
        if (!match) begin
          if (fill >= FILL_FULL) begin
            full = 1'b1;
          end else begin
            ins_we = 1'b1;
          end
        end
      end
      hsic_pkg::KIND_PROBE_NEW, hsic_pkg::KIND_PROBE_CONT: begin
        hit = match;
        if (kind_q == hsic_pkg::KIND_PROBE_NEW) begin
          cnt = '0;
        end
        if (match && (cnt != hsic_pkg::COUNT_MAX)) begin
          cnt = cnt + 1'b1;
        end
        cur_nx  = cnt;
        best_nx = (cnt > best_q) ? cnt : best_q;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // row RAM: write-back or clear sweep, read launched on the input transfer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rd_row_q <= mem_q[s_axis_tdata_i[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q  <= hsic_pkg::kind_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i;
    end
    if (advance) begin
      m_data_q <= {{hsic_pkg::OUT_PAD_W{1'b0}}, full, best_nx, cur_nx, hit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hsic_pkg::ST_CLEAR;
      clr_idx_q <= '0;
      pend_q    <= 1'b0;
      cur_q     <= '0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      pend_q    <= pend_d;
      if (advance) begin
        cur_q     <= cur_nx;
        best_q    <= best_nx;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // the best count never trails the running count
  a_best_ge_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q >= cur_q)
    else $error("best count below running count");

  // a clear transfer starts the fill sweep
  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tuser_i == hsic_pkg::KIND_CLEAR))
      |=> (state_q == hsic_pkg::ST_CLEAR) && (clr_idx_q == '0) && pend_q)
    else $error("clear did not start sweep");

  // insert or probe goes straight to evaluation
  a_lookup_evals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tuser_i != hsic_pkg::KIND_CLEAR))
      |=> (state_q == hsic_pkg::ST_EVAL))
    else $error("lookup did not reach evaluation");

  // a dropped insert never reports a hit
  a_full_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_data_q[0] && m_data_q[2*hsic_pkg::COUNT_W+1]))
    else $error("bucket_full together with hit");

endmodule

`default_nettype wire

/* tb/sv/hash_set_intersection_counter_tb.sv */
`timescale 1ns / 1ps

module hash_set_intersection_counter_tb;
  import hsic_pkg::*;

  localparam int unsigned BUCKET_CNT   = 1024;
  localparam int unsigned WAY_CNT      = 4;
  localparam int unsigned RAND_ITEMS   = 600;
  localparam int unsigned BURST_PROBES = 75;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned POOL_MAX     = 48;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] match_count;
    logic [COUNT_W-1:0] best_count;
    logic               bucket_full;
  } set_result_t;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    bit                 fixed;
    set_result_t        want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{KIND_PROBE_CONT, 32'h0000_0000, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
    '{KIND_PROBE_NEW,  32'h7FFF_FFFF, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
    '{KIND_INSERT,     32'h8000_0000, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0}},
    '{KIND_INSERT,     32'h8000_0000, 1'b1, '{1'b1, 16'd0, 16'd0, 1'b0}},
    '{KIND_PROBE_NEW,  32'h8000_0000, 1'b1, '{1'b1, 16'd1, 16'd1, 1'b0}},
    '{KIND_INSERT,     32'h7FFF_FFFF, 1'b0, '0},
    '{KIND_PROBE_CONT, 32'h7FFF_FFFF, 1'b0, '0},
    // fill bucket 0 to the limit, then overflow it
    '{KIND_INSERT,     32'h0000_0000, 1'b0, '0},
    '{KIND_INSERT,     32'h0000_0400, 1'b0, '0},
    '{KIND_INSERT,     32'hFFFF_FC00, 1'b0, '0},
    '{KIND_INSERT,     32'h0000_0800, 1'b1, '{1'b0, 16'd2, 16'd2, 1'b1}},
    '{KIND_INSERT,     32'h0000_0000, 1'b0, '0},
    '{KIND_PROBE_CONT, 32'h0000_0800, 1'b0, '0},
    '{KIND_PROBE_NEW,  32'h0000_0000, 1'b0, '0},
    '{KIND_PROBE_CONT, 32'hFFFF_FFFF, 1'b0, '0},
    // clear keeps both counts
    '{KIND_CLEAR,      32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd1, 16'd2, 1'b0}},
    '{KIND_PROBE_NEW,  32'h8000_0000, 1'b0, '0},
    '{KIND_INSERT,     32'h0000_0800, 1'b0, '0},
    '{KIND_PROBE_CONT, 32'h0000_0800, 1'b0, '0},
    '{KIND_PROBE_CONT, 32'h0000_0800, 1'b0, '0},
    '{KIND_PROBE_CONT, 32'h0000_0800, 1'b0, '0},
    '{KIND_CLEAR,      32'h0000_0000, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [31:0]           s_axis_tdata_i = '0;
  logic [1:0]            s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  hash_set_intersection_counter #(
    .BUCKETS(BUCKET_CNT),
    .WAYS   (WAY_CNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the reference set and the counters
  logic [VALUE_W-1:0] set_slot [BUCKET_CNT][WAY_CNT];
  int unsigned        set_fill [BUCKET_CNT];
  logic [COUNT_W-1:0] match_cnt = '0;
  logic [COUNT_W-1:0] best_cnt  = '0;

  set_result_t        pending_results [$];
  logic [VALUE_W-1:0] inserted_pool [$];

  bit          idle_on = 1'b1;
  int unsigned rx_stall = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_hits = 0;
  int unsigned n_drops = 0;
  int unsigned n_clears = 0;
  int unsigned n_results = 0;

  initial begin
    foreach (set_fill[i]) set_fill[i] = 0;
  end

  function automatic set_result_t predict_set_op(kind_e kind, logic [VALUE_W-1:0] value);
    set_result_t res;
    int unsigned bkt;
    bit          found;
    res   = '0;
    bkt   = value & (BUCKET_CNT - 1);
    found = 1'b0;
    for (int unsigned w = 0; w < set_fill[bkt] && w < WAY_CNT; w++) begin
      if (set_slot[bkt][w] == value) found = 1'b1;
    end
    case (kind)
      KIND_CLEAR: begin
        foreach (set_fill[i]) set_fill[i] = 0;
      end
      KIND_INSERT: begin
        if (found) begin
          res.hit = 1'b1;
        end else if (set_fill[bkt] >= WAY_CNT) begin
          res.bucket_full = 1'b1;
        end else begin
          set_slot[bkt][set_fill[bkt]] = value;
          set_fill[bkt]++;
        end
      end
      default: begin
        if (kind == KIND_PROBE_NEW) match_cnt = '0;
        if (found) begin
          res.hit = 1'b1;
          if (match_cnt != COUNT_MAX) match_cnt++;
        end
        if (match_cnt > best_cnt) best_cnt = match_cnt;
      end
    endcase
    res.match_count = match_cnt;
    res.best_count  = best_cnt;
    return res;
  endfunction

  task automatic send_item(kind_e kind, logic [VALUE_W-1:0] value, bit fixed,
                           set_result_t want);
    set_result_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = predict_set_op(kind, value);
    pending_results.push_back(fixed ? want : res);
    n_items++;
    if (res.hit) n_hits++;
    if (res.bucket_full) n_drops++;
    if (kind == KIND_CLEAR) n_clears++;
    if (kind == KIND_INSERT) begin
      inserted_pool.push_back(value);
      if (inserted_pool.size() > POOL_MAX) void'(inserted_pool.pop_front());
    end
  endtask

  // hold the sender until the result stream has drained
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && inserted_pool.size() != 0)
      return inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
    // a handful of crowded buckets so they run full
    if (r < 7) return ($urandom() & ~32'h3FF) | $urandom_range(0, 5);
    return $urandom();
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
    n_errors++;
  endtask

  // result side: check each transfer, then decide the next ready
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual tdata %h",
                 $realtime, m_axis_tdata_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.hit != m_axis_tdata_o[0])
          report_mismatch("hit", want.hit, m_axis_tdata_o[0]);
        if (want.match_count != m_axis_tdata_o[16:1])
          report_mismatch("match_count", want.match_count, m_axis_tdata_o[16:1]);
        if (want.best_count != m_axis_tdata_o[32:17])
          report_mismatch("best_count", want.best_count, m_axis_tdata_o[32:17]);
        if (want.bucket_full != m_axis_tdata_o[33])
          report_mismatch("bucket_full", want.bucket_full, m_axis_tdata_o[33]);
      end
    end
    if (rx_stall != 0) begin
      rx_stall--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(1, 14);
    end
    m_axis_tready_i <= (rx_stall == 0);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] burst_val;
    int unsigned        r;
    kind_e              kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIR_TABLE[i].kind, DIR_TABLE[i].value, DIR_TABLE[i].fixed,
                DIR_TABLE[i].want);
    end
    drain_results();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) kind = KIND_CLEAR;
      else if (r < 40) kind = KIND_INSERT;
      else if (r < 52) kind = KIND_PROBE_NEW;
      else kind = KIND_PROBE_CONT;
      send_item(kind, (kind == KIND_CLEAR) ? $urandom() : pick_value(), 1'b0, '0);
    end
    drain_results();

    // back-to-back hits on one value, no idling on either side
    idle_on = 1'b0;
    burst_val = $urandom();
    send_item(KIND_CLEAR, burst_val, 1'b0, '0);
    send_item(KIND_INSERT, burst_val, 1'b0, '0);
    send_item(KIND_PROBE_NEW, burst_val, 1'b0, '0);
    for (int unsigned i = 0; i < BURST_PROBES; i++) begin
      send_item(KIND_PROBE_CONT, burst_val, 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d items (%0d clears), %0d hits, %0d inserts dropped on full buckets.",
             n_items, n_clears, n_hits, n_drops);
    $display("Checked %0d results; best count reached %0d.", n_results, best_cnt);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/hsic_pkg.sv
src/hash_set_intersection_counter.sv
tb/sv/hash_set_intersection_counter_tb.sv
